### hw/rtl/xor_shift_random_with_range_roll_assert.svh
// Assertion macros shared by the range-roll generator RTL.
// Expects a clock named clk and an active-low async reset named arst_n in scope.
`ifndef XOR_SHIFT_RANDOM_WITH_RANGE_ROLL_ASSERT_SVH
`define XOR_SHIFT_RANDOM_WITH_RANGE_ROLL_ASSERT_SVH

// Same-cycle implication.
`define XSRR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define XSRR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/xsrr_pkg.sv
// Package for the range-roll generator: constants, action codes, step function
// and the control structs between the top level and the remainder unit. No dependencies.
package xsrr_pkg;

	localparam int unsigned StateW = 32;
	localparam int unsigned RawW   = 31;
	localparam int unsigned CntW   = $clog2(RawW);

	localparam logic [StateW-1:0] MixConst  = 32'h65AC9365;
	localparam logic [StateW-1:0] Low31Mask = 32'h7FFFFFFF;
	localparam logic [StateW-1:0] SeedReset = 32'h12345678;

	localparam logic [1:0] ActNext = 2'd0;
	localparam logic [1:0] ActRoll = 2'd1;
	localparam logic [1:0] ActLoad = 2'd2;

	typedef struct packed {
		logic            start;
		logic [RawW-1:0] dividend;
		logic [RawW-1:0] divisor;
	} rem_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rem_stat_t;

	// One generator step: XOR with the constant shifted right by the low two state bits, then shift-mix.
	function automatic logic [StateW-1:0] step(input logic [StateW-1:0] s);
		logic [StateW-1:0] t;
		t = s ^ (MixConst >> s[1:0]);
		return (t >> 4) ^ (t >> 3) ^ (t << 3) ^ (t << 4) ^ t;
	endfunction

endpackage

### hw/rtl/xsrr_in_if.sv
// Request channel of the range-roll generator: valid/ready plus request fields.
// Standalone; no package dependency.
interface xsrr_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [31:0]        load_value;
	logic signed [31:0] range_low;
	logic signed [31:0] range_high;

	modport source (output valid, action, load_value, range_low, range_high, input ready);
	modport sink   (input valid, action, load_value, range_low, range_high, output ready);
endinterface

### hw/rtl/xsrr_out_if.sv
// Result channel of the range-roll generator: valid/ready plus result fields.
// Standalone; no package dependency.
interface xsrr_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic [31:0]        state_now;
	logic               bad_range;

	modport source (output valid, value, state_now, bad_range, input ready);
	modport sink   (input valid, value, state_now, bad_range, output ready);
endinterface

### hw/rtl/xsrr_rem.sv
// Bit-serial restoring remainder unit: one compare/subtract per cycle over the RawW dividend bits.
// Uses xsrr_pkg and the assertion macro header.
`include "xor_shift_random_with_range_roll_assert.svh"

module xsrr_rem (
	input  logic                clk,
	input  logic                arst_n,
	input  xsrr_pkg::rem_req_t  req,
	output xsrr_pkg::rem_stat_t stat,
	output logic [xsrr_pkg::RawW-1:0] remainder
);

	logic                        busy_q;
	logic                        done_q;
	logic [xsrr_pkg::CntW-1:0]   cnt_q;
	logic [xsrr_pkg::RawW-1:0]   dvd_q;
	logic [xsrr_pkg::RawW-1:0]   dsr_q;
	logic [xsrr_pkg::RawW-1:0]   rem_q;

	logic [xsrr_pkg::RawW:0]     trial;
	logic [xsrr_pkg::RawW+1:0]   diff;

	// shift next dividend bit in, try the subtract; borrow means keep trial
	assign trial = {rem_q, dvd_q[xsrr_pkg::RawW-1]};
	assign diff  = {1'b0, trial} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= xsrr_pkg::CntW'(xsrr_pkg::RawW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (diff[xsrr_pkg::RawW+1])
				rem_q <= trial[xsrr_pkg::RawW-1:0];
			else
				rem_q <= diff[xsrr_pkg::RawW-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q;

	`XSRR_ASSERT_NOW(a_rem_bound, busy_q, rem_q < dsr_q, "partial remainder reached divisor")
	`XSRR_ASSERT_NXT(a_start_busy, req.start, busy_q, "unit not busy after start")
	`XSRR_ASSERT_NXT(a_done_pulse, done_q, !done_q && !busy_q, "done not a single pulse")

endmodule

### hw/rtl/xor_shift_random_with_range_roll.sv
// Range-roll random generator, top level. A request is taken only while the block
// is idle (ready high). Next, load, unused codes and rolls with a span below one
// register their result and go to the output step (S_OUT). A roll with a valid
// span first runs the 31-bit raw value through the bit-serial remainder unit in
// S_DIV, one bit per cycle, and then goes to S_OUT. The output step loads the result
// into an output register when that is free and returns to idle, so a new request is
// taken while the previous result still waits for its transfer; the new result then
// holds in its output step until that register frees.
// Depends on xsrr_pkg, xsrr_in_if, xsrr_out_if, xsrr_rem and the assertion header.
`include "xor_shift_random_with_range_roll_assert.svh"

module xor_shift_random_with_range_roll (
	input  logic        clk,
	input  logic        arst_n,
	xsrr_in_if.sink     req,
	xsrr_out_if.source  rsp
);

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_t;

	state_t                        state_q;
	logic [xsrr_pkg::StateW-1:0]   gen_q;
	logic [31:0]                   lo_q;
	logic [31:0]                   res_value_q;
	logic                          res_bad_q;
	logic                          roll_q;
	logic                          out_valid_q;
	logic [31:0]                   out_value_q;
	logic [31:0]                   out_state_q;
	logic                          out_bad_q;

	logic                          accept;
	logic [xsrr_pkg::StateW-1:0]   nxt;
	logic [31:0]                   span;
	logic                          span_bad;
	logic                          out_free;
	logic [31:0]                   roll_sum;
	xsrr_pkg::rem_req_t            rem_req;
	xsrr_pkg::rem_stat_t           rem_stat;
	logic [xsrr_pkg::RawW-1:0]     rem_val;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign nxt       = xsrr_pkg::step(gen_q);
	assign span      = req.range_high - req.range_low + 32'd1;
	assign span_bad  = (span == '0) || span[31];
	assign out_free  = !out_valid_q || rsp.ready;
	assign roll_sum  = lo_q + {1'b0, rem_val};

	assign rem_req.start    = accept && (req.action == xsrr_pkg::ActRoll) && !span_bad;
	assign rem_req.dividend = nxt[xsrr_pkg::RawW-1:0];
	assign rem_req.divisor  = span[xsrr_pkg::RawW-1:0];

	xsrr_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (rem_req),
		.stat      (rem_stat),
		.remainder (rem_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			gen_q       <= xsrr_pkg::SeedReset;
			out_valid_q <= 1'b0;
			roll_q      <= 1'b0;
			res_bad_q   <= 1'b0;
		end else begin
			// in S_OUT a taken result is replaced by the new one below
			if (out_valid_q && rsp.ready && state_q != S_OUT)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						roll_q      <= 1'b0;
						res_bad_q   <= 1'b0;
						res_value_q <= '0;
						lo_q        <= req.range_low;
						state_q     <= S_OUT;
						case (req.action)
							xsrr_pkg::ActNext: begin
								gen_q       <= nxt;
								res_value_q <= nxt & xsrr_pkg::Low31Mask;
							end
							xsrr_pkg::ActRoll: begin
								gen_q <= nxt;
								if (span_bad) begin
									res_value_q <= req.range_low;
									res_bad_q   <= 1'b1;
								end else begin
									roll_q  <= 1'b1;
									state_q <= S_DIV;
								end
							end
							xsrr_pkg::ActLoad: begin
								gen_q <= req.load_value;
							end
							default: begin
							end
						endcase
					end
				end
				S_DIV: begin
					if (rem_stat.done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_value_q <= roll_q ? roll_sum : res_value_q;
						out_state_q <= gen_q;
						out_bad_q   <= res_bad_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.value     = out_value_q;
	assign rsp.state_now = out_state_q;
	assign rsp.bad_range = out_bad_q;

	`XSRR_ASSERT_NOW(a_busy_in_div, rem_stat.busy, state_q == S_DIV, "remainder unit busy outside divide")
	`XSRR_ASSERT_NOW(a_done_in_div, rem_stat.done, state_q == S_DIV && roll_q, "remainder done unexpectedly")
	`XSRR_ASSERT_NXT(a_out_load, state_q == S_OUT && out_free, rsp.valid && state_q == S_IDLE, "result not registered")

endmodule

### tb/xsrr_checker.sv
// Scoreboard for the range-roll generator: watches the request and result channels,
// keeps its own copy of the generator state, and compares every result transfer.
// Depends on xsrr_pkg, xsrr_in_if and xsrr_out_if.
module xsrr_checker (
	input  logic clk,
	input  logic arst_n,
	xsrr_in_if   req,
	xsrr_out_if  rsp,
	output int   errors,
	output int   waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [31:0] value;
		logic [31:0]        state_now;
		logic               bad_range;
	} draw_t;

	draw_t       draws_due[$];
	logic [31:0] gen_state;

	initial errors = 0;

	function automatic logic [31:0] scramble(input logic [31:0] s);
		logic [31:0] t;
		t = s ^ (xsrr_pkg::MixConst >> s[1:0]);
		return t ^ (t << 3) ^ (t << 4) ^ (t >> 3) ^ (t >> 4);
	endfunction

	// Advances the tracked state as the block would and builds the expected result.
	function automatic draw_t predict_draw(input logic [1:0] act, input logic [31:0] load_v,
			input logic [31:0] lo, input logic [31:0] hi);
		draw_t       d;
		logic [31:0] raw;
		logic [31:0] span;
		d = '0;
		case (act)
			xsrr_pkg::ActNext: begin
				gen_state = scramble(gen_state);
				d.value = gen_state & xsrr_pkg::Low31Mask;
			end
			xsrr_pkg::ActRoll: begin
				gen_state = scramble(gen_state);
				raw = gen_state & xsrr_pkg::Low31Mask;
				span = hi - lo + 32'd1;
				// zero or negative span when read as signed
				if (span == 32'd0 || span[31]) begin
					d.value = lo;
					d.bad_range = 1'b1;
				end else begin
					d.value = lo + (raw % span);
				end
			end
			xsrr_pkg::ActLoad: gen_state = load_v;
			default: ;
		endcase
		d.state_now = gen_state;
		return d;
	endfunction

	task automatic report_error(input string msg);
		$display("%0t ns: %s", $time, msg);
		errors++;
	endtask

	task automatic check_result();
		draw_t want;
		if (draws_due.size() == 0) begin
			report_error($sformatf("result transfer with nothing expected: value %h state %h",
				rsp.value, rsp.state_now));
			return;
		end
		want = draws_due.pop_front();
		if (rsp.value !== want.value)
			report_error($sformatf("value: got %h, want %h", rsp.value, want.value));
		if (rsp.state_now !== want.state_now)
			report_error($sformatf("state_now: got %h, want %h", rsp.state_now, want.state_now));
		if (rsp.bad_range !== want.bad_range)
			report_error($sformatf("bad_range: got %b, want %b", rsp.bad_range, want.bad_range));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_state = xsrr_pkg::SeedReset;
			draws_due.delete();
			waiting = 0;
		end else begin
			if (rsp.valid && rsp.ready)
				check_result();
			if (req.valid && req.ready)
				draws_due.push_back(predict_draw(req.action, req.load_value,
					req.range_low, req.range_high));
			waiting = draws_due.size();
		end
	end

endmodule

### tb/xor_shift_random_with_range_roll_test.sv
// Top of the range-roll generator testbench: clock, reset, request stimulus,
// result back-pressure and the verdict; comparisons are done in xsrr_checker.
// Depends on xsrr_pkg, xsrr_in_if, xsrr_out_if, xsrr_checker and the RTL top.
module xor_shift_random_with_range_roll_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ActUnused = 2'd3;
	localparam int         NumRandom = 700;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors;
	int   waiting;
	int   burst_left = 0;
	int   sent[4] = '{0, 0, 0, 0};
	int   bad_rolls = 0;
	int   stall_mode = 0;
	int   stall_left = 0;

	xsrr_in_if  req_ch();
	xsrr_out_if rsp_ch();

	xor_shift_random_with_range_roll i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	xsrr_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.errors  (errors),
		.waiting (waiting)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] corner_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4: return 32'h0000_0001;
			default: return 32'h8000_0001;
		endcase
	endfunction

	// One request transfer; bursts of back-to-back requests with random gaps between.
	task automatic send_draw(input logic [1:0] act, input logic [31:0] load_v,
			input logic [31:0] lo, input logic [31:0] hi);
		int          gap;
		logic [31:0] span;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		req_ch.action = act;
		req_ch.load_value = load_v;
		req_ch.range_low = lo;
		req_ch.range_high = hi;
		req_ch.valid = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		burst_left--;
		sent[act]++;
		span = hi - lo + 32'd1;
		if (act == xsrr_pkg::ActRoll && (span == 32'd0 || span[31]))
			bad_rolls++;
	endtask

	task automatic drain();
		req_ch.valid = 1'b0;
		burst_left = 0;
		wait (waiting == 0);
		@(negedge clk);
	endtask

	// Result back-pressure: segments of always-ready, light, heavy and near-total stall.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(10, 150);
		end
		stall_left--;
		case (stall_mode)
			0: rsp_ch.ready = 1'b1;
			1: rsp_ch.ready = ($urandom_range(0, 3) != 0);
			2: rsp_ch.ready = ($urandom_range(0, 3) == 0);
			default: rsp_ch.ready = ($urandom_range(0, 19) == 0);
		endcase
	end

	initial begin
		int          pick;
		logic [1:0]  act;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] load_v;

		req_ch.valid = 1'b0;
		req_ch.action = xsrr_pkg::ActNext;
		req_ch.load_value = '0;
		req_ch.range_low = '0;
		req_ch.range_high = '0;
		rsp_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: sequence from the reset seed, span corners, loads, spare code
		send_draw(xsrr_pkg::ActNext, $urandom, $urandom, $urandom);
		send_draw(xsrr_pkg::ActNext, $urandom, $urandom, $urandom);
		send_draw(xsrr_pkg::ActNext, $urandom, $urandom, $urandom);
		send_draw(xsrr_pkg::ActRoll, $urandom, 32'd0, 32'd0);
		send_draw(xsrr_pkg::ActRoll, $urandom, 32'h8000_0000, 32'h7FFF_FFFF); // span wraps to zero
		send_draw(xsrr_pkg::ActRoll, $urandom, 32'd5, 32'd4);
		send_draw(xsrr_pkg::ActRoll, $urandom, 32'd10, 32'd3);
		send_draw(xsrr_pkg::ActRoll, $urandom, 32'd0, 32'h7FFF_FFFE);
		send_draw(xsrr_pkg::ActRoll, $urandom, 32'd0, 32'h7FFF_FFFF);
		send_draw(xsrr_pkg::ActRoll, $urandom, 32'h8000_0000, 32'hFFFF_FFFE);
		send_draw(xsrr_pkg::ActRoll, $urandom, 32'h7FFF_FFFF, 32'h8000_0000); // sum wraps
		send_draw(xsrr_pkg::ActRoll, $urandom, -32'sd10, 32'sd10);
		send_draw(xsrr_pkg::ActLoad, 32'h0000_0000, $urandom, $urandom);
		send_draw(xsrr_pkg::ActNext, $urandom, $urandom, $urandom);
		send_draw(xsrr_pkg::ActRoll, $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_draw(xsrr_pkg::ActLoad, 32'hFFFF_FFFF, $urandom, $urandom);
		send_draw(xsrr_pkg::ActNext, $urandom, $urandom, $urandom);
		send_draw(xsrr_pkg::ActLoad, 32'h0000_0003, $urandom, $urandom);
		send_draw(xsrr_pkg::ActRoll, $urandom, 32'd1, 32'd6);
		send_draw(ActUnused, $urandom, $urandom, $urandom);
		send_draw(xsrr_pkg::ActNext, $urandom, $urandom, $urandom);
		drain();

		for (int i = 0; i < NumRandom; i++) begin
			if (i == NumRandom / 2)
				drain();
			pick = $urandom_range(0, 99);
			act = (pick < 40) ? xsrr_pkg::ActNext : (pick < 75) ? xsrr_pkg::ActRoll :
				(pick < 92) ? xsrr_pkg::ActLoad : ActUnused;
			load_v = ($urandom_range(0, 9) == 0) ? corner_word() : $urandom;
			lo = $urandom;
			hi = $urandom;
			if (act == xsrr_pkg::ActRoll) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: hi = lo + $urandom_range(0, 99);
					4, 5: hi = lo + ($urandom >> $urandom_range(0, 31));
					6: hi = lo - $urandom_range(1, 1000);
					7, 8: begin
						lo = corner_word();
						hi = corner_word();
					end
					default: ;
				endcase
			end
			send_draw(act, load_v, lo, hi);
		end

		req_ch.valid = 1'b0;
		wait (waiting == 0);
		repeat (50) @(posedge clk);
		$display("Covered %0d next, %0d roll, %0d load and %0d spare-code requests,",
			sent[xsrr_pkg::ActNext], sent[xsrr_pkg::ActRoll], sent[xsrr_pkg::ActLoad],
			sent[ActUnused]);
		$display("with %0d rolls on an empty or negative span, under random back-pressure.",
			bad_rolls);
		if (errors == 0 && waiting == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timed out with %0d results outstanding", waiting);
		$display("Some tests failed");
		$finish;
	end

endmodule
